// File: rtl/rqco_pkg.sv
// rqco_pkg: shared types, sizes and helpers for the class-ordered ready queue
// no dependencies
package rqco_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CLASS_COUNT = 4;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CLS_W = 3;
  localparam int CIDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_DEQUEUE = 2'd2,
    ACT_INSERT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_TAIL
  } state_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [CLS_W-1:0] cls;
  } entry_t;

  // wraps a circular address, offset is at most QUEUE_DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [CLS_W-1:0] fix_class(input logic [CLS_W-1:0] c);
    if (c == '0) begin
      return CLS_W'(1);
    end else if ((CLS_W + 1)'(c) > (CLS_W + 1)'(CLASS_COUNT)) begin
      return CLS_W'(CLASS_COUNT);
    end
    return c;
  endfunction

endpackage

// File: rtl/rqco_if.sv
// rqco_req_if, rqco_rsp_if: valid/ready channels for requests and responses
// no dependencies
interface rqco_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] entry_id;
  logic [2:0] entry_class;
  modport source (output valid, action, entry_id, entry_class, input ready);
  modport sink (input valid, action, entry_id, entry_class, output ready);
endinterface

interface rqco_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_id;
  logic [2:0] out_class;
  logic [4:0] occupancy;
  logic [4:0] count_class_one;
  logic [4:0] count_class_two;
  logic [4:0] count_class_three;
  logic [4:0] count_class_four;
  modport source (output valid, status, out_id, out_class, occupancy, count_class_one,
                  count_class_two, count_class_three, count_class_four, input ready);
  modport sink (input valid, status, out_id, out_class, occupancy, count_class_one,
                count_class_two, count_class_three, count_class_four, output ready);
endinterface

// File: rtl/ready_queue_class_ordered.sv
// ready_queue_class_ordered: circular queue in a ram with ordered insert
// depends on rqco_pkg, rqco_if, rqco_ram
//
//   channel  dir  role
//   req      in   action, entry_id, entry_class
//   rsp      out  status, head entry, occupancy, class counts
//
// one word at a time; a new word is taken only when the last response is gone
// append and status-only words finish on acceptance; rotate and dequeue add a ram read (S_HEAD)
// ordered insert: walks every held entry in S_SCAN, then S_TAIL; one ram read per entry scanned
// rst clears head, count and class counters; ram contents are not cleared
// a stalled rsp holds the block with the response registered
module ready_queue_class_ordered (
  input logic clk,
  input logic rst,
  rqco_req_if.sink   req,
  rqco_rsp_if.source rsp
);

  localparam int AW = rqco_pkg::ADDR_W;
  localparam int CW = rqco_pkg::CNT_W;
  localparam int LW = rqco_pkg::CLS_W;
  localparam int NC = rqco_pkg::CLASS_COUNT;
  localparam int IW = rqco_pkg::CIDX_W;

  rqco_pkg::state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] cls_cnt [NC];
  logic [AW-1:0] idx, idx_next;
  logic found, found_next;
  rqco_pkg::entry_t carry, carry_next;
  rqco_pkg::action_t act;
  logic [LW-1:0] cls;
  logic rsp_valid;
  logic [1:0] status;
  logic [7:0] out_id;
  logic [LW-1:0] out_class;

  logic accept, finish, cnt_inc, cnt_dec;
  logic [LW-1:0] cnt_cls;
  rqco_pkg::status_t status_d;
  rqco_pkg::entry_t out_d;
  rqco_pkg::action_t req_act;
  logic [LW-1:0] req_cls;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rqco_pkg::entry_t ram_wdata, ram_rdata;

  rqco_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign req.ready = (state == rqco_pkg::S_IDLE) && !rsp_valid;
  assign accept = req.valid && req.ready;
  assign req_act = rqco_pkg::action_t'(req.action);
  assign req_cls = rqco_pkg::fix_class(req.entry_class);

  always_comb begin
    state_next = state;
    case (state)
      rqco_pkg::S_IDLE: begin
        if (accept) begin
          if ((req_act == rqco_pkg::ACT_ROTATE || req_act == rqco_pkg::ACT_DEQUEUE)
              && held != '0) begin
            state_next = rqco_pkg::S_HEAD;
          end else if (req_act == rqco_pkg::ACT_INSERT && held != CW'(rqco_pkg::QUEUE_DEPTH)) begin
            state_next = (held == '0) ? rqco_pkg::S_TAIL : rqco_pkg::S_SCAN;
          end
        end
      end
      rqco_pkg::S_HEAD: state_next = rqco_pkg::S_IDLE;
      rqco_pkg::S_SCAN: begin
        if (CW'(idx) == held - CW'(1)) begin
          state_next = rqco_pkg::S_TAIL;
        end
      end
      rqco_pkg::S_TAIL: state_next = rqco_pkg::S_IDLE;
      default: state_next = rqco_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    finish = 1'b0;
    status_d = rqco_pkg::ST_OK;
    out_d = '0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    cnt_cls = cls;
    head_next = head;
    held_next = held;
    idx_next = idx;
    found_next = found;
    carry_next = carry;
    ram_we = 1'b0;
    ram_waddr = head;
    ram_wdata = carry;
    ram_re = 1'b0;
    ram_raddr = head;
    case (state)
      rqco_pkg::S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          found_next = 1'b0;
          carry_next.id = req.entry_id;
          carry_next.cls = req_cls;
          cnt_cls = req_cls;
          case (req_act)
            rqco_pkg::ACT_APPEND, rqco_pkg::ACT_INSERT: begin
              if (held == CW'(rqco_pkg::QUEUE_DEPTH)) begin
                finish = 1'b1;
                status_d = rqco_pkg::ST_FULL;
              end else if (req_act == rqco_pkg::ACT_APPEND) begin
                finish = 1'b1;
                ram_we = 1'b1;
                ram_waddr = rqco_pkg::wrap_add(head, held);
                ram_wdata = carry_next;
                held_next = held + CW'(1);
                cnt_inc = 1'b1;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: begin
              if (held == '0) begin
                finish = 1'b1;
                status_d = rqco_pkg::ST_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
          endcase
        end
      end
      rqco_pkg::S_HEAD: begin
        finish = 1'b1;
        out_d = ram_rdata;
        head_next = rqco_pkg::wrap_add(head, CW'(1));
        cnt_cls = ram_rdata.cls;
        if (act == rqco_pkg::ACT_ROTATE) begin
          ram_we = 1'b1;
          ram_waddr = rqco_pkg::wrap_add(head, held);
          ram_wdata = ram_rdata;
        end else begin
          held_next = held - CW'(1);
          cnt_dec = 1'b1;
        end
      end
      rqco_pkg::S_SCAN: begin
        if (found || ram_rdata.cls >= cls) begin
          ram_we = 1'b1;
          ram_waddr = rqco_pkg::wrap_add(head, CW'(idx));
          ram_wdata = carry;
          carry_next = ram_rdata;
          found_next = 1'b1;
        end
        if (CW'(idx) != held - CW'(1)) begin
          idx_next = idx + AW'(1);
          ram_re = 1'b1;
          ram_raddr = rqco_pkg::wrap_add(head, CW'(idx) + CW'(1));
        end
      end
      rqco_pkg::S_TAIL: begin
        finish = 1'b1;
        ram_we = 1'b1;
        ram_waddr = rqco_pkg::wrap_add(head, held);
        ram_wdata = carry;
        held_next = held + CW'(1);
        cnt_inc = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqco_pkg::S_IDLE;
      head <= '0;
      held <= '0;
      rsp_valid <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        cls_cnt[k] <= '0;
      end
    end else begin
      state <= state_next;
      head <= head_next;
      held <= held_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cnt_inc) begin
        cls_cnt[IW'(cnt_cls - LW'(1))] <= cls_cnt[IW'(cnt_cls - LW'(1))] + CW'(1);
      end else if (cnt_dec) begin
        cls_cnt[IW'(cnt_cls - LW'(1))] <= cls_cnt[IW'(cnt_cls - LW'(1))] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    found <= found_next;
    carry <= carry_next;
    if (accept) begin
      act <= req_act;
      cls <= req_cls;
    end
    if (finish) begin
      status <= status_d;
      out_id <= out_d.id;
      out_class <= out_d.cls;
    end
  end

  logic [4:0] cnt_out [4];
  for (genvar k = 0; k < 4; k++) begin : g_cnt
    if (k < NC) begin : g_on
      assign cnt_out[k] = 5'(cls_cnt[k]);
    end else begin : g_off
      assign cnt_out[k] = '0;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = status;
  assign rsp.out_id = out_id;
  assign rsp.out_class = out_class;
  assign rsp.occupancy = 5'(held);
  assign rsp.count_class_one = cnt_out[0];
  assign rsp.count_class_two = cnt_out[1];
  assign rsp.count_class_three = cnt_out[2];
  assign rsp.count_class_four = cnt_out[3];

  logic [CW+3:0] cnt_sum;
  always_comb begin
    cnt_sum = '0;
    for (int k = 0; k < NC; k++) begin
      cnt_sum = cnt_sum + (CW + 4)'(cls_cnt[k]);
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(rqco_pkg::QUEUE_DEPTH))
    else $error("occupancy beyond depth");
  a_cnt_sum: assert property (@(posedge clk) disable iff (rst)
    cnt_sum == (CW + 4)'(held))
    else $error("class counts disagree with occupancy");
  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid)
    else $error("response lost while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != rqco_pkg::S_IDLE |-> !req.ready)
    else $error("word taken while busy");
`endif

endmodule

// File: rtl/rqco_ram.sv
// rqco_ram: entry store, one write port, one read port with registered data
// depends on rqco_pkg
module rqco_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [rqco_pkg::ADDR_W-1:0] waddr,
  input  rqco_pkg::entry_t          wdata,
  input  logic                      re,
  input  logic [rqco_pkg::ADDR_W-1:0] raddr,
  output rqco_pkg::entry_t          rdata
);

  rqco_pkg::entry_t mem [rqco_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
